/* src/wpd_pkg.sv */
// Shared types, constants and codes for the waveform peak decimator.
package wpd_pkg;

  // Sizes of the design.
  localparam int CHANNELS    = 8;
  localparam int COLUMNS     = 256;
  localparam int QUEUE_DEPTH = 4;

  // Field widths fixed by the interface.
  localparam int CHAN_W     = 3;
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 15;
  localparam int SQ_W       = 15;
  localparam int GAIN_W     = 16;
  localparam int WIN_W      = 16;
  localparam int COL_OUT_W  = 8;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived widths.
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_W   = SAMPLE_W + GAIN_W;

  // Sign code kept per window.
  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  // Phase mode register codes.
  typedef enum logic [1:0] {
    MODE_SIGNED    = 2'd0,
    MODE_MAGNITUDE = 2'd1,
    MODE_POS_ONLY  = 2'd2,
    MODE_NEG_FOLD  = 2'd3
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SQUELCH = 2'd0,
    REG_GAIN    = 2'd1,
    REG_PHASE   = 2'd2,
    REG_WINDOW  = 2'd3
  } cfg_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic [SQ_W-1:0]   squelch;
    logic [GAIN_W-1:0] gain;
    phase_t            phase;
    logic [WIN_W-1:0]  window;
  } cfg_t;

  // Conditioned sample passed from the front to the back.
  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [MAG_W-1:0]  mag;
    sign_t             sign;
  } item_t;

endpackage

/* src/wpd_sample_if.sv */
// Input channel interface: one tagged audio sample per transfer.
interface wpd_sample_if
  import wpd_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [CHAN_W-1:0]          chan;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, chan, sample_in, input ready);
  modport sink   (input valid, chan, sample_in, output ready);
endinterface

/* src/wpd_column_if.sv */
// Output channel interface: one finished column per transfer.
interface wpd_column_if
  import wpd_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [CHAN_W-1:0]         chan_out;
  logic [COL_OUT_W-1:0]      column;
  logic signed [LEVEL_W-1:0] level;

  modport source (output valid, chan_out, column, level, input ready);
  modport sink   (input valid, chan_out, column, level, output ready);
endinterface

/* src/wpd_front.sv */
// Front end: accepts samples, applies squelch, gain and phase mode.
module wpd_front
  import wpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  wpd_sample_if.sink        samples,
  output logic              q_valid,
  input  logic              q_ready,
  output item_t             q_item
);

  logic                  s1_valid;
  logic [CHAN_W-1:0]     s1_chan;
  logic [PROD_W-1:0]     s1_prod;
  sign_t                 s1_sign;

  logic [SAMPLE_W:0]     ext;
  logic [SAMPLE_W:0]     abs_mag;
  logic [SAMPLE_W-1:0]   sq_mag;
  logic [PROD_W-1:0]     prod;
  sign_t                 raw_sign;

  logic [PROD_W-9:0]     scaled;
  logic [MAG_W-1:0]      sat_mag;
  logic [MAG_W-1:0]      fin_mag;
  sign_t                 fin_sign;
  logic                  in_range;
  logic                  advance;

  // Magnitude, squelch and gain multiply on the incoming sample.
  always_comb begin
    ext     = {samples.sample_in[SAMPLE_W-1], samples.sample_in};
    abs_mag = samples.sample_in[SAMPLE_W-1] ? (~ext + 1'b1) : ext;
    if (abs_mag > {2'b00, cfg.squelch}) begin
      sq_mag = SAMPLE_W'(abs_mag - {2'b00, cfg.squelch});
    end else begin
      sq_mag = '0;
    end
    prod = PROD_W'(sq_mag) * PROD_W'(cfg.gain);
    if (abs_mag == '0) begin
      raw_sign = SIGN_NONE;
    end else if (samples.sample_in[SAMPLE_W-1]) begin
      raw_sign = SIGN_NEG;
    end else begin
      raw_sign = SIGN_POS;
    end
  end

  // Shift out the gain fraction, saturate and apply the phase mode.
  always_comb begin
    scaled   = s1_prod[PROD_W-1:8];
    sat_mag  = (|scaled[PROD_W-9:MAG_W]) ? {MAG_W{1'b1}} : scaled[MAG_W-1:0];
    fin_mag  = sat_mag;
    fin_sign = s1_sign;
    case (cfg.phase)
      MODE_SIGNED: begin
      end
      MODE_MAGNITUDE: begin
        fin_sign = SIGN_POS;
      end
      MODE_POS_ONLY: begin
        if (s1_sign == SIGN_NEG) fin_mag = '0;
      end
      MODE_NEG_FOLD: begin
        if (s1_sign == SIGN_POS) fin_mag = '0;
        else fin_sign = SIGN_POS;
      end
      default: begin
      end
    endcase
    if (fin_mag == '0) fin_sign = SIGN_NONE;
  end

  // Samples of channels beyond the configured count are dropped here.
  assign in_range      = {1'b0, s1_chan} < (CHAN_W+1)'(CHANNELS);
  assign q_valid       = s1_valid && in_range;
  assign q_item.chan   = s1_chan;
  assign q_item.mag    = fin_mag;
  assign q_item.sign   = fin_sign;
  assign advance       = !s1_valid || !in_range || q_ready;
  assign samples.ready = advance;

  // Product register between the multiplier and the saturation logic.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= samples.valid;
    end
    if (advance && samples.valid) begin
      s1_chan <= samples.chan;
      s1_prod <= prod;
      s1_sign <= raw_sign;
    end
  end

endmodule

/* src/wpd_queue.sv */
// Short queue of conditioned samples between the front end and the back end.
module wpd_queue
  import wpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  item_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign wr_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_item  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_item;
  end

endmodule

/* src/wpd_back.sv */
// Back end: per-channel peak hold, window counting and column output register.
module wpd_back
  import wpd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  output logic         q_ready,
  input  item_t        q_item,
  wpd_column_if.source columns
);

  logic [MAG_W-1:0]  peak_mag     [CHANNELS];
  sign_t             first_sign   [CHANNELS];
  logic [WIN_W-1:0]  window_count [CHANNELS];
  logic [COL_W-1:0]  column_count [CHANNELS];

  logic                      out_valid;
  logic [CHAN_W-1:0]         out_chan;
  logic [COL_OUT_W-1:0]      out_col;
  logic signed [LEVEL_W-1:0] out_level;

  logic [CH_IDX_W-1:0] idx;
  logic [MAG_W-1:0]    peak_next;
  sign_t               sign_next;
  logic [WIN_W-1:0]    count_next;
  logic [WIN_W-1:0]    len;
  logic                done;
  logic [COL_W-1:0]    col_cur;
  logic [COL_W-1:0]    col_next;
  logic [LEVEL_W-1:0]  peak_ext;
  logic [LEVEL_W-1:0]  level_next;
  logic                go;

  // Merge the sample into its channel's window.
  always_comb begin
    idx        = q_item.chan[CH_IDX_W-1:0];
    sign_next  = (first_sign[idx] == SIGN_NONE) ? q_item.sign : first_sign[idx];
    peak_next  = (q_item.mag > peak_mag[idx]) ? q_item.mag : peak_mag[idx];
    count_next = window_count[idx] + 1'b1;
    len        = (cfg.window == '0) ? WIN_W'(1) : cfg.window;
    done       = count_next >= len;
    col_cur    = column_count[idx];
    col_next   = (col_cur == COL_W'(COLUMNS - 1)) ? '0 : col_cur + 1'b1;
    peak_ext   = {1'b0, peak_next};
    case (sign_next)
      SIGN_POS: level_next = peak_ext;
      SIGN_NEG: level_next = ~peak_ext + 1'b1;
      default:  level_next = '0;
    endcase
  end

  // The back end moves only when the output register is free or draining.
  assign q_ready = !out_valid || columns.ready;
  assign go      = q_valid && q_ready;

  // Per-channel window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        peak_mag[i]     <= '0;
        first_sign[i]   <= SIGN_NONE;
        window_count[i] <= '0;
        column_count[i] <= '0;
      end
    end else if (go) begin
      if (done) begin
        peak_mag[idx]     <= '0;
        first_sign[idx]   <= SIGN_NONE;
        window_count[idx] <= '0;
        column_count[idx] <= col_next;
      end else begin
        peak_mag[idx]     <= peak_next;
        first_sign[idx]   <= sign_next;
        window_count[idx] <= count_next;
      end
    end
  end

  // Output register holding one finished column.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid && done;
    end
    if (go && done) begin
      out_chan  <= q_item.chan;
      out_col   <= COL_OUT_W'(col_cur);
      out_level <= level_next;
    end
  end

  assign columns.valid    = out_valid;
  assign columns.chan_out = out_chan;
  assign columns.column   = out_col;
  assign columns.level    = out_level;

endmodule

/* src/waveform_peak_decimator.sv */
// Top level of the waveform peak decimator: configuration registers and datapath.
//
//  Port      Dir  Handshake      Payload
//  samples   in   valid/ready    chan, sample_in
//  columns   out  valid/ready    chan_out, column, level
//  cfg_*     in   cfg_we only    cfg_index, cfg_data
//
// One sample is taken per cycle while samples.ready is high. A column passes the
// multiplier register, the queue and the output register after the sample that
// closes its window. Reset is synchronous; it clears window state, valid flags
// and queue pointers. A stalled output holds the back end; the four-entry queue
// then fills and the front end holds, and only then does samples.ready drop.
module waveform_peak_decimator
  import wpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wpd_sample_if.sink            samples,
  wpd_column_if.source          columns
);

  cfg_t  cfg;
  logic  q_wr_valid;
  logic  q_wr_ready;
  item_t q_wr_item;
  logic  q_rd_valid;
  logic  q_rd_ready;
  item_t q_rd_item;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.squelch <= '0;
      cfg.gain    <= GAIN_W'(256);
      cfg.phase   <= MODE_SIGNED;
      cfg.window  <= WIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SQUELCH: cfg.squelch <= cfg_data[SQ_W-1:0];
        REG_GAIN:    cfg.gain    <= cfg_data[GAIN_W-1:0];
        REG_PHASE:   cfg.phase   <= phase_t'(cfg_data[1:0]);
        REG_WINDOW:  cfg.window  <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wpd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .q_valid (q_wr_valid),
    .q_ready (q_wr_ready),
    .q_item  (q_wr_item)
  );

  wpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_item  (q_rd_item)
  );

  wpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_rd_valid),
    .q_ready (q_rd_ready),
    .q_item  (q_rd_item),
    .columns (columns)
  );

  // No column is offered in the cycle after reset.
  a_no_out_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !columns.valid)
    else $error("column offered right after reset");

  // A level is never the most negative code.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    columns.valid |-> (columns.level != 16'sh8000))
    else $error("level out of range");

  // A stalled column holds the back end.
  a_stall_holds_back: assert property (@(posedge clk) disable iff (rst)
    (columns.valid && !columns.ready) |-> !q_rd_ready)
    else $error("back end moved while column stalled");

  // The input is held back only when the queue is full.
  a_ready_from_queue: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (q_wr_valid && !q_wr_ready))
    else $error("input stalled without a full queue");

endmodule
